// ===== hw/rtl/apcp_pkg.sv =====
package apcp_pkg;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PLAY   = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_LOOP   = 3'd3,
    ACT_STEREO = 3'd4,
    ACT_MONO0  = 3'd5,
    ACT_MONO1  = 3'd6
  } action_e;

  typedef enum logic [9:0] {
    PS_IDLE  = 10'b00_0000_0001,
    PS_S_HI  = 10'b00_0000_0010,
    PS_S_MID = 10'b00_0000_0100,
    PS_S_LO  = 10'b00_0000_1000,
    PS_E_HI  = 10'b00_0001_0000,
    PS_E_MID = 10'b00_0010_0000,
    PS_E_LO  = 10'b00_0100_0000,
    PS_MONO0 = 10'b00_1000_0000,
    PS_MONO1 = 10'b01_0000_0000,
    PS_SKIP  = 10'b10_0000_0000
  } parse_state_e;

  localparam int unsigned AddrWidth = 24;
  localparam int unsigned LenWidth  = 25;

  localparam logic [7:0] OpStartA  = 8'h14;
  localparam logic [7:0] OpStartB  = 8'h15;
  localparam logic [7:0] OpEndA    = 8'h24;
  localparam logic [7:0] OpEndB    = 8'h25;
  localparam logic [7:0] OpPlayA   = 8'h74;
  localparam logic [7:0] OpPlayB   = 8'h75;
  localparam logic [7:0] OpStopA   = 8'h84;
  localparam logic [7:0] OpStopB   = 8'h85;
  localparam logic [7:0] OpMono0   = 8'hA0;
  localparam logic [7:0] OpMono1   = 8'hB1;
  localparam logic [7:0] OpSkipA1  = 8'hA1;
  localparam logic [7:0] OpSkipA4  = 8'hA4;
  localparam logic [7:0] OpSkipA5  = 8'hA5;
  localparam logic [7:0] OpSkipB0  = 8'hB0;
  localparam logic [7:0] OpSkipB4  = 8'hB4;
  localparam logic [7:0] OpSkipB5  = 8'hB5;

  typedef struct packed {
    logic                        is_playing;
    logic signed [LenWidth-1:0]  sample_length;
    logic        [AddrWidth-1:0] sample_start;
    action_e                     action;
  } result_t;

endpackage

// ===== hw/rtl/audio_playback_command_parser.sv =====
// The command byte is held in the input register; the result register loads from it once the output is free.
// Throughput: one command byte per cycle unless stalled; decode, byte-lane update
// and the 25-bit length subtraction sit between the input and result registers. A
// held result stalls the input only once the input register is also full.
// Reset (rst_ni low, asynchronous): both stages empty, parser idle, start and
// end addresses zero, not playing.
module audio_playback_command_parser
  import apcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] cmd_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] action, [26:3] sample_start, [51:27] sample_length, [52] is_playing,
  // [55:53] zero
  output logic [55:0] m_axis_tdata_o
);

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 out_valid_q;
  result_t              out_q;

  parse_state_e         state_q, state_d;
  logic [AddrWidth-1:0] start_q, start_d;
  logic [AddrWidth-1:0] end_q, end_d;
  logic                 play_q, play_d;
  action_e              act;
  logic [LenWidth-1:0]  len;
  logic                 advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    state_d = state_q;
    start_d = start_q;
    end_d   = end_q;
    play_d  = play_q;
    act     = ACT_NONE;
    unique case (state_q)
      PS_IDLE: begin
        unique case (in_byte_q)
          OpStartA, OpStartB: state_d = PS_S_HI;
          OpEndA, OpEndB:     state_d = PS_E_HI;
          OpPlayA, OpPlayB: begin
            play_d = 1'b1;
            act    = ACT_PLAY;
          end
          OpStopA, OpStopB: begin
            play_d = 1'b0;
            act    = ACT_STOP;
          end
          OpMono0: state_d = PS_MONO0;
          OpMono1: state_d = PS_MONO1;
          OpSkipA1, OpSkipA4, OpSkipA5, OpSkipB0, OpSkipB4, OpSkipB5: state_d = PS_SKIP;
          default: ;
        endcase
      end
      PS_S_HI: begin
        start_d[23:16] = in_byte_q;
        state_d        = PS_S_MID;
      end
      PS_S_MID: begin
        start_d[15:8] = in_byte_q;
        state_d       = PS_S_LO;
      end
      PS_S_LO: begin
        start_d[7:0] = in_byte_q;
        state_d      = PS_IDLE;
        if (play_q) begin
          act = ACT_LOOP;
        end
      end
      PS_E_HI: begin
        end_d[23:16] = in_byte_q;
        state_d      = PS_E_MID;
      end
      PS_E_MID: begin
        end_d[15:8] = in_byte_q;
        state_d     = PS_E_LO;
      end
      PS_E_LO: begin
        end_d[7:0] = in_byte_q;
        state_d    = PS_IDLE;
        act        = ACT_STEREO;
      end
      PS_MONO0: begin
        state_d = PS_IDLE;
        act     = ACT_MONO0;
      end
      PS_MONO1: begin
        state_d = PS_IDLE;
        act     = ACT_MONO1;
      end
      default: state_d = PS_IDLE;
    endcase
  end

  assign len = {1'b0, end_d} - {1'b0, start_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= PS_IDLE;
      start_q     <= '0;
      end_q       <= '0;
      play_q      <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        start_q     <= start_d;
        end_q       <= end_d;
        play_q      <= play_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_q.action        <= act;
      out_q.sample_start  <= start_d;
      out_q.sample_length <= len;
      out_q.is_playing    <= play_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q};

  // Held result must still match the parser state it was taken from.
  a_len_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.sample_length == ({1'b0, end_q} - {1'b0, start_q})))
    else $error("result length out of step with address registers");

  a_start_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.sample_start == start_q && out_q.is_playing == play_q))
    else $error("result start or playing flag out of step with state");

  a_loop_needs_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.action == ACT_LOOP) |-> out_q.is_playing)
    else $error("set loop issued while not playing");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("parse state lost its one-hot code");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled input byte was dropped or overwritten");

endmodule
